@@ sv/bcx_pkg.sv @@
// Shared constants, types and stage records for the Box-Cox transform unit.
// No dependencies; every other file but bcx_if imports this package.
package bcx_pkg;

    localparam int LOG_STEPS      = 30;  // fraction bits of log2, one squaring per stage
    localparam int TAYLOR_TERMS   = 20;  // highest series index of 2^f
    localparam int TAYLOR_STAGES  = TAYLOR_TERMS - 1;  // terms 2..TAYLOR_TERMS, 3 stages each
    localparam int DIV_STEP_BITS  = 4;   // quotient bits per divider stage
    localparam int DIV_WIDTH      = 64;
    localparam int DIV_STAGES     = DIV_WIDTH / DIV_STEP_BITS;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] OUT_MIN = 48'sh8000_0000_0000;

    localparam logic signed [7:0] N_CLAMP = 8'sd34;  // 2^n alone overflows the output
    localparam logic signed [7:0] N_WIDE  = 8'sd3;   // divide by lambda, not 8*lambda

    typedef logic signed [34:0] log2_t;    // Q5.30
    typedef logic signed [47:0] result_t;  // Q31.16

    // travels alongside the 2^f series
    typedef struct packed {
        logic              last;
        logic              invalid;
        logic signed [7:0] n;
        result_t           log_res;
        logic [31:0]       g;
    } exp_side_t;

    // travels alongside the divider
    typedef struct packed {
        logic    last;
        logic    invalid;
        logic    sat_big;
        logic    neg;
        result_t log_res;
    } div_tag_t;

endpackage

@@ sv/bcx_if.sv @@
// Valid/ready channel interfaces for the Box-Cox transform unit.
// No dependencies.
interface bcx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_value;
    logic        window_last_in;

    modport source (output valid, output sample_value, output window_last_in, input ready);
    modport sink   (input valid, input sample_value, input window_last_in, output ready);
endinterface

interface bcx_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] transformed_value;
    logic               invalid_sample;
    logic               result_saturated;
    logic               window_last_out;

    modport source (output valid, output transformed_value, output invalid_sample,
                    output result_saturated, output window_last_out, input ready);
    modport sink   (input valid, input transformed_value, input invalid_sample,
                    input result_saturated, input window_last_out, output ready);
endinterface

@@ sv/box_cox_transform_unit.sv @@
// Box-Cox transform unit: top level, stage registers for exponent, series and clamp.
// Depends on bcx_pkg, bcx_if, bcx_log2 and bcx_div.
//
// Takes one positive Q16.16 sample per cycle unless the output stalls and
// returns ln(x) when lambda is zero, else (x^lambda - 1)/lambda, as signed
// Q31.16 saturated to 48 bits. Fully pipelined: one item per clock sustained
// while results are taken; 109 register stages lie between input handshake
// and output, the first loaded at the handshake edge. The depth is set by the
// 30 squaring stages of log2, 19 series terms of 2^f at three stages each
// (multiply, reciprocal multiply, correct-and-accumulate) and a 16-stage
// radix-16 divider. The whole pipe advances together and stops only while a
// result waits unread; no item is lost or repeated across a stall. Write
// lambda only while the pipe is empty. A zero sample yields 0 with
// invalid_sample set. window_last_in rides through to window_last_out.
module box_cox_transform_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    bcx_in_if.sink      sample_in,
    bcx_out_if.source   result_out
);
    import bcx_pkg::*;

    localparam int NT = TAYLOR_STAGES;

    logic signed [15:0] lambda_reg;
    logic               adv;

    // lambda register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg <= '0;
        end
        else if (cfg_we)
        begin
            lambda_reg <= $signed(cfg_wdata);
        end
    end

    // global pipe enable: move unless the output holds an untaken item
    logic out_valid_reg;
    assign adv             = !out_valid_reg || result_out.ready;
    assign sample_in.ready = adv;

    // ---------------- log2 ----------------
    logic  lg_valid;
    log2_t lg_val;
    logic  lg_last;
    logic  lg_invalid;

    bcx_log2 u_log2 (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (sample_in.valid),
        .x           (sample_in.sample_value),
        .in_last     (sample_in.window_last_in),
        .out_valid   (lg_valid),
        .lg          (lg_val),
        .out_last    (lg_last),
        .out_invalid (lg_invalid)
    );

    // ---------------- z = lambda*log2(x), ln path product ----------------
    logic signed [50:0] z_next;
    logic [34:0]        lg_mag;
    logic [64:0]        lnprod_next;

    logic signed [50:0] z_reg;
    logic [64:0]        lnprod_reg;
    logic               lgneg_reg;
    logic               zv_reg;
    logic               zlast_reg;
    logic               zinv_reg;

    assign z_next      = 51'(lambda_reg) * 51'(lg_val);
    assign lg_mag      = lg_val[34] ? 35'(-lg_val) : 35'(lg_val);
    assign lnprod_next = 65'(lg_mag) * 65'(LN2_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zv_reg <= 1'b0;
        end
        else if (adv)
        begin
            zv_reg <= lg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg      <= z_next;
            lnprod_reg <= lnprod_next;
            lgneg_reg  <= lg_val[34];
            zlast_reg  <= lg_last;
            zinv_reg   <= lg_invalid;
        end
    end

    // ---------------- split z, g = f*ln2, round ln result ----------------
    logic [50:0]       zb;
    logic [31:0]       f32;
    logic [63:0]       gprod;
    logic [20:0]       ln_r;
    exp_side_t         f_next;
    exp_side_t         f_side_reg;
    logic              fv_reg;

    function automatic logic [20:0] prod_round(input logic [64:0] p);
        prod_round = p[64:44] + 21'(p[43]);
    endfunction

    assign zb    = $unsigned(z_reg) + (51'd1 << 49);
    assign f32   = zb[42:11];
    assign gprod = 64'(f32) * 64'(LN2_Q32);
    assign ln_r  = prod_round(lnprod_reg);

    always_comb
    begin
        f_next.last    = zlast_reg;
        f_next.invalid = zinv_reg;
        f_next.n       = $signed(zb[50:43] - 8'd64);
        f_next.g       = gprod[63:32];
        f_next.log_res = lgneg_reg ? -result_t'(ln_r) : result_t'(ln_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg <= zv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_side_reg <= f_next;
        end
    end

    // ---------------- 2^f = sum of g^k/k! ----------------
    logic        ta_v   [0:NT-1];
    logic [31:0] ta_p   [0:NT-1];
    logic [32:0] ta_sum [0:NT-1];
    exp_side_t   ta_side[0:NT-1];
    logic        tb_v   [0:NT-1];
    logic [31:0] tb_p   [0:NT-1];
    logic [31:0] tb_q   [0:NT-1];
    logic [32:0] tb_sum [0:NT-1];
    exp_side_t   tb_side[0:NT-1];
    logic        tc_v   [0:NT-1];
    logic [31:0] tc_term[0:NT-1];
    logic [32:0] tc_sum [0:NT-1];
    exp_side_t   tc_side[0:NT-1];

    for (genvar j = 0; j < NT; j++)
    begin : g_term
        localparam int          K     = j + 2;
        localparam logic [35:0] RECIP = 36'((64'd1 << 36) / K);

        logic [31:0] term_in;
        logic [32:0] sum_in;
        exp_side_t   side_in;
        logic        v_in;
        logic [63:0] pa;
        logic [67:0] pb;
        logic [36:0] qk;
        logic [31:0] rem;
        logic [31:0] term_c;

        if (j == 0)
        begin : g_first
            // term 1 is g itself, sum starts at 1 + g
            assign term_in = f_side_reg.g;
            assign sum_in  = {1'b1, f_side_reg.g};
            assign side_in = f_side_reg;
            assign v_in    = fv_reg;
        end
        else
        begin : g_rest
            assign term_in = tc_term[j-1];
            assign sum_in  = tc_sum[j-1];
            assign side_in = tc_side[j-1];
            assign v_in    = tc_v[j-1];
        end

        assign pa     = 64'(term_in) * 64'(side_in.g);
        // quotient estimate is exact or one low
        assign pb     = 68'(ta_p[j]) * 68'(RECIP);
        assign qk     = 37'(tb_q[j]) * 37'(K);
        assign rem    = 32'(37'(tb_p[j]) - qk);
        assign term_c = (rem >= 32'(K)) ? tb_q[j] + 32'd1 : tb_q[j];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ta_v[j] <= 1'b0;
                tb_v[j] <= 1'b0;
                tc_v[j] <= 1'b0;
            end
            else if (adv)
            begin
                ta_v[j] <= v_in;
                tb_v[j] <= ta_v[j];
                tc_v[j] <= tb_v[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ta_p[j]    <= pa[63:32];
                ta_sum[j]  <= sum_in;
                ta_side[j] <= side_in;
                tb_p[j]    <= ta_p[j];
                tb_q[j]    <= pb[67:36];
                tb_sum[j]  <= ta_sum[j];
                tb_side[j] <= ta_side[j];
                tc_term[j] <= term_c;
                tc_sum[j]  <= tb_sum[j] + 33'(term_c);
                tc_side[j] <= tb_side[j];
            end
        end
    end

    // ---------------- scale by 2^n, subtract one, pick divisor ----------------
    logic [32:0]       e_val;
    exp_side_t         e_side;
    logic signed [7:0] n_e;
    logic [4:0]        sh_up;
    logic [6:0]        sh_dn;
    logic [63:0]       big_shift;
    logic [39:0]       m_dn;
    logic [35:0]       mm;
    logic [15:0]       lam_mag;
    logic [63:0]       an_next;
    logic [18:0]       ad_next;
    logic              numneg;
    div_tag_t          dtag_next;

    assign e_val     = tc_sum[NT-1];
    assign e_side    = tc_side[NT-1];
    assign n_e       = e_side.n;
    assign sh_up     = 5'(n_e - N_WIDE);
    assign sh_dn     = 7'(-n_e);
    assign big_shift = 64'(e_val) << sh_up;
    assign m_dn      = (40'(e_val) + (40'd1 << 6'(sh_dn - 7'd1))) >> sh_dn[5:0];
    assign lam_mag   = lambda_reg[15] ? 16'(-lambda_reg) : 16'(lambda_reg);

    always_comb
    begin
        an_next = '0;
        numneg  = 1'b0;
        mm      = '0;
        dtag_next.sat_big = 1'b0;
        if (n_e >= N_CLAMP)
        begin
            dtag_next.sat_big = 1'b1;
        end
        else if (n_e >= N_WIDE)
        begin
            // never negative here since 2^f >= 1
            an_next = big_shift - (64'd1 << 29);
        end
        else
        begin
            if (n_e >= 8'sd0)
            begin
                mm = 36'(e_val) << n_e[1:0];
            end
            else if (sh_dn < 7'd40)
            begin
                mm = 36'(m_dn);
            end
            if (mm >= (36'd1 << 32))
            begin
                an_next = 64'(mm - (36'd1 << 32));
            end
            else
            begin
                an_next = 64'((36'd1 << 32) - mm);
                numneg  = 1'b1;
            end
        end
        ad_next           = (n_e >= N_WIDE) ? 19'(lam_mag) : {lam_mag, 3'b000};
        dtag_next.neg     = numneg ^ lambda_reg[15];
        dtag_next.last    = e_side.last;
        dtag_next.invalid = e_side.invalid;
        dtag_next.log_res = e_side.log_res;
    end

    logic        ev_reg;
    logic [63:0] an_reg;
    logic [18:0] ad_reg;
    div_tag_t    dtag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= 1'b0;
        end
        else if (adv)
        begin
            ev_reg <= tc_v[NT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            an_reg   <= an_next;
            ad_reg   <= ad_next;
            dtag_reg <= dtag_next;
        end
    end

    // ---------------- rounded division ----------------
    logic        dv_valid;
    logic [63:0] dv_quot;
    div_tag_t    dv_tag;

    bcx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ev_reg),
        .an        (an_reg),
        .ad        (ad_reg),
        .in_tag    (dtag_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_tag   (dv_tag)
    );

    // ---------------- select, clamp, output register ----------------
    result_t res_next;
    logic    sat_next;

    always_comb
    begin
        res_next = '0;
        sat_next = 1'b0;
        if (dv_tag.invalid)
        begin
            res_next = '0;
        end
        else if (lambda_reg == 16'sd0)
        begin
            res_next = dv_tag.log_res;
        end
        else if (dv_tag.sat_big)
        begin
            sat_next = 1'b1;
            res_next = lambda_reg[15] ? OUT_MIN : OUT_MAX;
        end
        else if (!dv_tag.neg || dv_quot == 64'd0)
        begin
            if (dv_quot > 64'h7FFF_FFFF_FFFF)
            begin
                sat_next = 1'b1;
                res_next = OUT_MAX;
            end
            else
            begin
                res_next = $signed(dv_quot[47:0]);
            end
        end
        else
        begin
            if (dv_quot > 64'h8000_0000_0000)
            begin
                sat_next = 1'b1;
                res_next = OUT_MIN;
            end
            else
            begin
                res_next = $signed(-dv_quot[47:0]);
            end
        end
    end

    result_t out_value_reg;
    logic    out_inv_reg;
    logic    out_sat_reg;
    logic    out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_value_reg <= res_next;
            out_inv_reg   <= dv_tag.invalid;
            out_sat_reg   <= sat_next;
            out_last_reg  <= dv_tag.last;
        end
    end

    assign result_out.valid             = out_valid_reg;
    assign result_out.transformed_value = out_value_reg;
    assign result_out.invalid_sample    = out_inv_reg;
    assign result_out.result_saturated  = out_sat_reg;
    assign result_out.window_last_out   = out_last_reg;

endmodule

@@ sv/bcx_log2.sv @@
// Pipelined log2 of an unsigned Q16.16 sample, result Q5.30.
// Depends on bcx_pkg.
module bcx_log2 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [31:0]   x,
    input  logic          in_last,
    output logic          out_valid,
    output bcx_pkg::log2_t lg,
    output logic          out_last,
    output logic          out_invalid
);
    import bcx_pkg::*;

    logic [4:0]  lead;
    logic [31:0] m0;

    logic        v_reg    [0:LOG_STEPS];
    logic        last_reg [0:LOG_STEPS];
    logic        inv_reg  [0:LOG_STEPS];
    logic [31:0] m_reg    [0:LOG_STEPS];
    logic [29:0] frac_reg [0:LOG_STEPS];
    logic [4:0]  p_reg    [0:LOG_STEPS];

    // leading one position
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                lead = 5'(i);
            end
        end
    end

    assign m0 = x << (5'd31 - lead);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg[0]    <= m0;
            frac_reg[0] <= '0;
            p_reg[0]    <= lead;
            last_reg[0] <= in_last;
            inv_reg[0]  <= (x == 32'd0);
        end
    end

    // one squaring of the Q1.31 mantissa per stage
    for (genvar i = 1; i <= LOG_STEPS; i++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] t;

        assign sq = 64'(m_reg[i-1]) * 64'(m_reg[i-1]);
        assign t  = sq[63:31];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[i]    <= t[32] ? t[32:1] : t[31:0];
                frac_reg[i] <= frac_reg[i-1] | (t[32] ? (30'd1 << (LOG_STEPS - i)) : 30'd0);
                p_reg[i]    <= p_reg[i-1];
                last_reg[i] <= last_reg[i-1];
                inv_reg[i]  <= inv_reg[i-1];
            end
        end
    end

    assign out_valid   = v_reg[LOG_STEPS];
    assign out_last    = last_reg[LOG_STEPS];
    assign out_invalid = inv_reg[LOG_STEPS];
    // integer part p-16 in five bits is p with its top bit flipped
    assign lg = $signed({~p_reg[LOG_STEPS][4], p_reg[LOG_STEPS][3:0], frac_reg[LOG_STEPS]});

endmodule

@@ sv/bcx_div.sv @@
// Pipelined unsigned divider with round-half-up, 64-bit dividend, 19-bit divisor.
// Depends on bcx_pkg.
module bcx_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [63:0]       an,
    input  logic [18:0]       ad,
    input  bcx_pkg::div_tag_t in_tag,
    output logic              out_valid,
    output logic [63:0]       quot,
    output bcx_pkg::div_tag_t out_tag
);
    import bcx_pkg::*;

    logic        v_reg   [0:DIV_STAGES];
    logic [63:0] dvd_reg [0:DIV_STAGES];
    logic [18:0] rem_reg [0:DIV_STAGES];
    logic [18:0] dsr_reg [0:DIV_STAGES];
    div_tag_t    tag_reg [0:DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    // add half the divisor up front for rounding
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvd_reg[0] <= an + 64'(ad >> 1);
            rem_reg[0] <= '0;
            dsr_reg[0] <= ad;
            tag_reg[0] <= in_tag;
        end
    end

    // restoring division; quotient bits shift in where dividend bits leave
    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_div
        logic [18:0] r_c;
        logic [63:0] d_c;
        logic [19:0] trial;

        always_comb
        begin
            r_c   = rem_reg[s-1];
            d_c   = dvd_reg[s-1];
            trial = '0;
            for (int b = 0; b < DIV_STEP_BITS; b++)
            begin
                trial = {r_c, d_c[63]};
                d_c   = {d_c[62:0], 1'b0};
                if (trial >= {1'b0, dsr_reg[s-1]})
                begin
                    trial  = trial - {1'b0, dsr_reg[s-1]};
                    d_c[0] = 1'b1;
                end
                r_c = trial[18:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dvd_reg[s] <= d_c;
                rem_reg[s] <= r_c;
                dsr_reg[s] <= dsr_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES];
    assign quot      = dvd_reg[DIV_STAGES];
    assign out_tag   = tag_reg[DIV_STAGES];

endmodule

@@ sv/bcx_checker.sv @@
// Port-level checks for the Box-Cox transform unit, bound to the top level.
// Depends on bcx_pkg and box_cox_transform_unit.
module bcx_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [47:0] value,
    input logic               inv,
    input logic               sat,
    input logic               last
);
    import bcx_pkg::*;

    // zero sample gives a clean zero, never a clamp
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inv |-> value == 48'sd0 && !sat)
        else $error("invalid item with nonzero result");

    // a clamped result sits on a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat |-> value == OUT_MAX || value == OUT_MIN)
        else $error("saturated item off the range limits");

    // empty output stage never holds back the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output empty");

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(inv)
            && $stable(sat) && $stable(last))
        else $error("stalled item changed");

endmodule

bind box_cox_transform_unit bcx_checker u_bcx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .value     (result_out.transformed_value),
    .inv       (result_out.invalid_sample),
    .sat       (result_out.result_saturated),
    .last      (result_out.window_last_out)
);
